// ===== rtl/core/qcph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcph_pkg
// shared types, keyword tables and word parsing helpers for the query
// classifier and partition hash
// ----------------------------------------------------------------------------
package qcph_pkg;

    // partition width, 1..32; the result port carries 16 bits of it
    localparam int PARTITION_BITS = 16;
    localparam int PART_PORT_W    = 16;
    localparam int HASH_W         = PART_PORT_W;
    localparam int PART_W         = (PARTITION_BITS < PART_PORT_W) ? PARTITION_BITS
                                                                   : PART_PORT_W;
    localparam logic [HASH_W-1:0] PART_MASK = HASH_W'((64'd1 << PART_W) - 64'd1);

    // fnv-1a 64-bit constants; only the low bits reach the result, and low
    // product bits depend only on low operand bits
    localparam logic [63:0] FNV_BASIS_FULL = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME_FULL = 64'h00000100000001b3;
    localparam logic [HASH_W-1:0] FNV_BASIS = FNV_BASIS_FULL[HASH_W-1:0];
    localparam logic [HASH_W-1:0] FNV_PRIME = FNV_PRIME_FULL[HASH_W-1:0];

    localparam int MAX_WORD = 7;
    localparam int CHARS_W  = 8 * MAX_WORD;
    localparam int LEN_W    = 4;

    // first word codes
    localparam logic [3:0] KW_NONE    = 4'd0;
    localparam logic [3:0] KW_SHOW    = 4'd1;
    localparam logic [3:0] KW_PROFILE = 4'd4;
    localparam logic [3:0] KW_CREATE  = 4'd5;
    localparam logic [3:0] KW_ALTER   = 4'd7;
    localparam logic [3:0] KW_MERGE   = 4'd10;

    localparam int N_FIRST  = 10;
    localparam int N_SCHEMA = 5;

    typedef enum logic [1:0] {
        QC_READ  = 2'd0,
        QC_WRITE = 2'd1,
        QC_DDL   = 2'd2,
        QC_ADMIN = 2'd3
    } t_qclass;

    // one input beat
    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_space_name;
        logic       last_byte;
    } t_beat;

    // word parser state
    typedef struct packed {
        logic [CHARS_W-1:0] chars;
        logic [LEN_W-1:0]   len;
        logic               too_long;
        logic [1:0]         seen;
        logic [3:0]         first;
        logic               schema;
    } t_pstate;

    localparam t_pstate PSTATE_RESET = '{
        chars: '0, len: '0, too_long: 1'b0, seen: 2'd0, first: KW_NONE, schema: 1'b0
    };

    // keywords packed oldest char high, in code order SHOW..MERGE
    localparam logic [CHARS_W-1:0] FIRST_KW [N_FIRST] = '{
        56'h0000_0053484F57,     // show
        56'h0000_0000555345,     // use
        56'h4558504C41494E,      // explain
        56'h50524F46494C45,      // profile
        56'h00_435245415445,     // create
        56'h0000_0044524F50,     // drop
        56'h0000_414C544552,     // alter
        56'h0000_0000534554,     // set
        56'h00_44454C455445,     // delete
        56'h0000_4D45524745      // merge
    };
    localparam logic [LEN_W-1:0] FIRST_LEN [N_FIRST] = '{
        4'd4, 4'd3, 4'd7, 4'd7, 4'd6, 4'd4, 4'd5, 4'd3, 4'd6, 4'd5
    };

    localparam logic [CHARS_W-1:0] SCHEMA_KW [N_SCHEMA] = '{
        56'h0000_5350414345,     // space
        56'h0000_0000544147,     // tag
        56'h0000_0045444745,     // edge
        56'h0000_494E444558,     // index
        56'h0000_4C4142454C      // label
    };
    localparam logic [LEN_W-1:0] SCHEMA_LEN [N_SCHEMA] = '{
        4'd5, 4'd3, 4'd4, 4'd5, 4'd5
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic kw_match(input t_pstate s, input logic [CHARS_W-1:0] kw,
                                      input logic [LEN_W-1:0] n);
        return !s.too_long && (s.len == n) && (s.chars == kw);
    endfunction

    // add one non-separator query char to the word in progress
    function automatic t_pstate append_char(input t_pstate s, input logic [7:0] c);
        t_pstate    r;
        logic [7:0] u;
        r = s;
        u = c;
        if ((c >= 8'h61) && (c <= 8'h7A)) begin
            u = c - 8'h20;
        end
        if (s.seen < 2'd2) begin
            if (s.len < LEN_W'(MAX_WORD)) begin
                r.chars = {s.chars[CHARS_W-9:0], u};
                r.len   = s.len + LEN_W'(1);
            end else begin
                r.too_long = 1'b1;
            end
        end
        return r;
    endfunction

    // close the word in progress and record it as first or second word
    function automatic t_pstate finish_word(input t_pstate s);
        t_pstate    r;
        logic [3:0] code;
        logic       hit;
        r    = s;
        code = KW_NONE;
        hit  = 1'b0;
        if ((s.len != '0) || s.too_long) begin
            for (int i = N_FIRST - 1; i >= 0; i--) begin
                if (kw_match(s, FIRST_KW[i], FIRST_LEN[i])) begin
                    code = 4'(i + 1);
                end
            end
            for (int i = 0; i < N_SCHEMA; i++) begin
                if (kw_match(s, SCHEMA_KW[i], SCHEMA_LEN[i])) begin
                    hit = 1'b1;
                end
            end
            if (s.seen == 2'd0) begin
                r.first = code;
            end else if (s.seen == 2'd1) begin
                r.schema = hit;
            end
            if (s.seen < 2'd2) begin
                r.seen = s.seen + 2'd1;
            end
            r.chars    = '0;
            r.len      = '0;
            r.too_long = 1'b0;
        end
        return r;
    endfunction

    function automatic t_qclass classify(input t_pstate s);
        t_qclass q;
        if (s.first inside {[KW_SHOW:KW_PROFILE]}) begin
            q = QC_ADMIN;
        end else if ((s.first inside {[KW_CREATE:KW_ALTER]}) && s.schema) begin
            q = QC_DDL;
        end else if (s.first inside {[KW_CREATE:KW_MERGE]}) begin
            q = QC_WRITE;
        end else begin
            q = QC_READ;
        end
        return q;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/query_classify_and_partition_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// query_classify_and_partition_hash
// classifies a query as read, write, ddl or admin from its first two words
// and hashes query text plus space name into a partition number
// ----------------------------------------------------------------------------
// usage
//   input channel: one byte per beat, query text first and then the space
//   name (i_is_space_name high), i_last_byte high on the final byte
//   output channel: one result per request, given for the last beat only;
//   o_done_res is always high on a result
//   latency: the result is valid the cycle after its last beat is taken
//   throughput: one beat per cycle unless a result waits with i_out_ready
//   low; the hash, the word parser and the keyword compare are all
//   combinational from the parser and hash registers to the result register
//   stall: the result register holds while i_out_ready is low; while a
//   result waits no input beat is taken, whatever its kind, and a beat is
//   taken in the same cycle the waiting result leaves
//   reset: synchronous, active low; hash back to the fnv basis, parser
//   cleared, result register empty. after each last beat the hash and
//   parser restart the same way, so requests follow back to back
// ----------------------------------------------------------------------------
module query_classify_and_partition_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input beats
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_char_byte,
    input  wire logic        i_is_space_name,
    input  wire logic        i_last_byte,
    // results
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_query_class,
    output logic [15:0]      o_partition,
    output logic             o_done_res
);

    qcph_pkg::t_beat             w_beat;
    logic                        w_accept;
    logic                        w_load;
    qcph_pkg::t_qclass           w_class;
    logic [qcph_pkg::HASH_W-1:0] w_hash_next;

    // result register
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [1:0]                  r_class;
    logic [15:0]                 r_part;

    assign w_beat = '{
        char_byte:     i_char_byte,
        is_space_name: i_is_space_name,
        last_byte:     i_last_byte
    };

    // room when the result register is empty or being emptied this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = w_accept && i_last_byte;

    qcph_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_beat   (w_beat),
        .o_class  (w_class)
    );

    qcph_hash u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_beat      (w_beat),
        .o_hash_next (w_hash_next)
    );

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_class <= w_class;
            r_part  <= w_hash_next & qcph_pkg::PART_MASK;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_query_class = r_class;
    assign o_partition   = r_part;
    assign o_done_res    = 1'b1;

`ifndef SYNTHESIS
    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_out_valid)
        else $error("no result after last beat");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_load && (!o_out_valid || i_out_ready)) |=> !o_out_valid)
        else $error("result without a last beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !w_accept)
        else $error("beat taken while a result is stuck");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/qcph_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcph_parse
// splits query bytes into words, keeps the first two and gives the query
// class for the beat that ends a request
// ----------------------------------------------------------------------------
module qcph_parse (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire qcph_pkg::t_beat  i_beat,
    output qcph_pkg::t_qclass     o_class
);

    qcph_pkg::t_pstate r_state;
    qcph_pkg::t_pstate n_state;
    qcph_pkg::t_pstate w_step;
    qcph_pkg::t_pstate w_end;
    logic              w_sep;

    // space-name bytes and whitespace both close the current word
    always_comb begin
        w_sep  = i_beat.is_space_name || qcph_pkg::is_ws(i_beat.char_byte);
        w_step = w_sep ? r_state : qcph_pkg::append_char(r_state, i_beat.char_byte);
        w_end  = qcph_pkg::finish_word(w_step);
        if (i_beat.last_byte) begin
            n_state = qcph_pkg::PSTATE_RESET;
        end else begin
            n_state = w_sep ? w_end : w_step;
        end
        o_class = qcph_pkg::classify(w_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qcph_pkg::PSTATE_RESET;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_beat.last_byte) |=> (r_state == qcph_pkg::PSTATE_RESET))
        else $error("parser state not cleared after last beat");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/qcph_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcph_hash
// fnv-1a running hash over every byte, low bits only, restarting after
// the last beat of each request
// ----------------------------------------------------------------------------
module qcph_hash (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire qcph_pkg::t_beat             i_beat,
    output logic [qcph_pkg::HASH_W-1:0]      o_hash_next
);

    logic [qcph_pkg::HASH_W-1:0]   r_hash;
    logic [qcph_pkg::HASH_W-1:0]   n_hash;
    logic [qcph_pkg::HASH_W-1:0]   w_mix;
    logic [2*qcph_pkg::HASH_W-1:0] w_prod;

    // byte is sign-extended before the xor
    always_comb begin
        w_mix       = r_hash ^ {{(qcph_pkg::HASH_W-8){i_beat.char_byte[7]}},
                                i_beat.char_byte};
        w_prod      = w_mix * {{qcph_pkg::HASH_W{1'b0}}, qcph_pkg::FNV_PRIME};
        o_hash_next = w_prod[qcph_pkg::HASH_W-1:0];
        n_hash      = i_beat.last_byte ? qcph_pkg::FNV_BASIS : o_hash_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= qcph_pkg::FNV_BASIS;
        end else if (i_accept) begin
            r_hash <= n_hash;
        end
    end

`ifndef SYNTHESIS
    a_basis_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_beat.last_byte) |=> (r_hash == qcph_pkg::FNV_BASIS))
        else $error("hash not restarted after last beat");
`endif

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for query_classify_and_partition_hash: streams requests
// of query text and space name one byte per beat, predicts the query class
// and the fnv-1a partition of each request, and checks every result
// ----------------------------------------------------------------------------
module tb;

    localparam int          RAND_BEATS  = 925;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          LONG_HOLD   = 300;   // long receiver hold-off, in cycles
    localparam int          HOLD_AT     = 30;    // results taken before the hold-off
    localparam int          SETTLE      = 4;     // cycles after the last expected result
    localparam logic [63:0] HASH_SEED   = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_MULT   = 64'h00000100000001b3;
    localparam logic [63:0] PART_KEEP   = (64'd1 << qcph_pkg::PARTITION_BITS) - 64'd1;
    localparam logic [7:0]  CH_SPACE    = 8'h20;
    localparam logic [7:0]  CH_TAB      = 8'h09;
    localparam logic [7:0]  CH_CR       = 8'h0D;

    // codes of the first word, in keyword table order
    typedef enum int {
        LW_NONE, LW_SHOW, LW_USE, LW_EXPLAIN, LW_PROFILE, LW_CREATE,
        LW_DROP, LW_ALTER, LW_SET, LW_DELETE, LW_MERGE
    } t_lead;

    typedef struct {
        logic [7:0] ch;
        logic       sp;
    } t_req_byte;

    typedef struct packed {
        qcph_pkg::t_qclass cls;
        logic [15:0]       part;
    } t_verdict;

    // predicts class and partition per request and checks the result beats
    class hash_scoreboard;
        string       lead_words[10];
        string       schema_words[5];
        t_verdict    pending_q[$];
        int          errors;
        int          class_hits[4];
        logic [63:0] fnv;
        logic [55:0] tok_chars;
        int          tok_len;
        bit          tok_overflow;
        int          tok_count;
        t_lead       lead;
        bit          second_schema;

        function new();
            lead_words   = '{"SHOW", "USE", "EXPLAIN", "PROFILE", "CREATE",
                             "DROP", "ALTER", "SET", "DELETE", "MERGE"};
            schema_words = '{"SPACE", "TAG", "EDGE", "INDEX", "LABEL"};
            errors = 0;
            foreach (class_hits[k]) class_hits[k] = 0;
            restart();
        endfunction

        function void restart();
            fnv           = HASH_SEED;
            tok_chars     = '0;
            tok_len       = 0;
            tok_overflow  = 1'b0;
            tok_count     = 0;
            lead          = LW_NONE;
            second_schema = 1'b0;
        endfunction

        function bit word_matches(string kw);
            logic [55:0] kw_bits;
            kw_bits = '0;
            for (int k = 0; k < kw.len(); k++) kw_bits = {kw_bits[47:0], kw[k]};
            return !tok_overflow && tok_len == kw.len() && tok_chars == kw_bits;
        endfunction

        function void close_word();
            if (tok_len == 0 && !tok_overflow) return;
            if (tok_count == 0) begin
                lead = LW_NONE;
                for (int k = 0; k < 10; k++) begin
                    if (lead == LW_NONE && word_matches(lead_words[k])) lead = t_lead'(k + 1);
                end
            end else if (tok_count == 1) begin
                second_schema = 1'b0;
                foreach (schema_words[k]) begin
                    if (word_matches(schema_words[k])) second_schema = 1'b1;
                end
            end
            if (tok_count < 2) tok_count++;
            tok_chars    = '0;
            tok_len      = 0;
            tok_overflow = 1'b0;
        endfunction

        function void note_beat(logic [7:0] ch, logic sp, logic fin);
            logic [7:0] up;
            t_verdict   v;
            // byte taken as a signed char before the xor
            fnv = (fnv ^ {{56{ch[7]}}, ch}) * HASH_MULT;
            if (sp || ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
                close_word();
            end else if (tok_count < 2) begin
                up = ch;
                if (ch >= 8'h61 && ch <= 8'h7A) up = ch - 8'h20;
                if (tok_len < 7) begin
                    tok_chars = {tok_chars[47:0], up};
                    tok_len++;
                end else begin
                    tok_overflow = 1'b1;
                end
            end
            if (!fin) return;
            close_word();
            if (lead >= LW_SHOW && lead <= LW_PROFILE) begin
                v.cls = qcph_pkg::QC_ADMIN;
            end else if (lead >= LW_CREATE && lead <= LW_ALTER && second_schema) begin
                v.cls = qcph_pkg::QC_DDL;
            end else if (lead >= LW_CREATE) begin
                v.cls = qcph_pkg::QC_WRITE;
            end else begin
                v.cls = qcph_pkg::QC_READ;
            end
            v.part = fnv[15:0] & PART_KEEP[15:0];
            pending_q.push_back(v);
            restart();
        endfunction

        function void check_result(logic [1:0] cls, logic [15:0] part, logic done);
            t_verdict v;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual class %0d partition %h",
                         $time, cls, part);
                return;
            end
            v = pending_q.pop_front();
            class_hits[v.cls]++;
            if (cls !== v.cls) begin
                errors++;
                $display("%0t: query_class expected %0d actual %0d", $time, v.cls, cls);
            end
            if (part !== v.part) begin
                errors++;
                $display("%0t: partition expected %h actual %h", $time, v.part, part);
            end
            if (done !== 1'b1) begin
                errors++;
                $display("%0t: done_res expected 1 actual %b", $time, done);
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_char_byte     = 8'h00;
    logic        i_is_space_name = 1'b0;
    logic        i_last_byte     = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [1:0]  o_query_class;
    logic [15:0] o_partition;
    logic        o_done_res;

    hash_scoreboard sb;
    t_req_byte      req_q[$];
    int             beats_sent   = 0;
    int             cycle_count  = 0;
    int             stall_cycles = 0;
    bit             send_burst   = 1'b0;

    query_classify_and_partition_hash i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_char_byte     (i_char_byte),
        .i_is_space_name (i_is_space_name),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_query_class   (o_query_class),
        .o_partition     (o_partition),
        .o_done_res      (o_done_res)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // beats and results are sampled as they stood at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            sb.note_beat(i_char_byte, i_is_space_name, i_last_byte);
        end
        if (i_rst_n && i_in_valid && !o_in_ready) stall_cycles <= stall_cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_query_class, o_partition, o_done_res);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_q.size());
            $display("query_classify_and_partition_hash: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // request building
    // ------------------------------------------------------------------
    function automatic void push_byte(logic [7:0] c, logic sp);
        t_req_byte b;
        b.ch = c;
        b.sp = sp;
        req_q.push_back(b);
    endfunction

    function automatic void push_text(string s, logic sp);
        for (int k = 0; k < s.len(); k++) push_byte(s[k], sp);
    endfunction

    // keyword with each letter in a random case
    function automatic void push_word(string s);
        logic [7:0] c;
        for (int k = 0; k < s.len(); k++) begin
            c = s[k];
            if ($urandom_range(0, 1) == 1 && c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
            push_byte(c, 1'b0);
        end
    endfunction

    function automatic logic [7:0] sep_char();
        logic [7:0] c;
        c = 8'($urandom_range(9, 14));
        if (c > CH_CR) c = CH_SPACE;
        return c;
    endfunction

    function automatic void push_junk(int n);
        logic [7:0] c;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: c = 8'h41 + 8'($urandom_range(0, 25));
                1: c = 8'h61 + 8'($urandom_range(0, 25));
                2: c = 8'h30 + 8'($urandom_range(0, 9));
                default: begin
                    c = 8'($urandom);
                    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) c = 8'h5F;
                end
            endcase
            push_byte(c, 1'b0);
        end
    endfunction

    // mostly well-formed requests with random content, the rest noise
    function automatic void build_request();
        string kw;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 14)) push_byte(8'($urandom), 1'($urandom_range(0, 1)));
            return;
        end
        repeat ($urandom_range(0, 2)) push_byte(sep_char(), 1'b0);
        kw = sb.lead_words[$urandom_range(0, 9)];
        case ($urandom_range(0, 9))
            0, 1: push_junk($urandom_range(1, 10));
            2: push_word({kw, "S"});
            3: push_word(kw.substr(0, kw.len() - 2));
            default: push_word(kw);
        endcase
        if ($urandom_range(0, 5) != 0) begin
            repeat ($urandom_range(1, 3)) push_byte(sep_char(), 1'b0);
            kw = sb.schema_words[$urandom_range(0, 4)];
            case ($urandom_range(0, 5))
                0: push_junk($urandom_range(1, 9));
                1: push_word({kw, "ES"});
                default: push_word(kw);
            endcase
            repeat ($urandom_range(0, 2)) begin
                push_byte(sep_char(), 1'b0);
                push_junk($urandom_range(1, 5));
            end
        end
        if ($urandom_range(0, 3) == 0) push_byte(sep_char(), 1'b0);
        if ($urandom_range(0, 7) != 0) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b1);
        end
        // now and then query text again after the space name
        if ($urandom_range(0, 9) == 0) push_junk($urandom_range(1, 4));
    endfunction

    // ------------------------------------------------------------------
    // sender: one beat per byte, last flag on the final one
    // ------------------------------------------------------------------
    task automatic send_request();
        int gap;
        foreach (req_q[k]) begin
            gap = send_burst ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid      <= 1'b1;
            i_char_byte     <= req_q[k].ch;
            i_is_space_name <= req_q[k].sp;
            i_last_byte     <= (k == req_q.size() - 1);
            do @(posedge i_clk); while (!o_in_ready);
            beats_sent++;
        end
        req_q.delete();
        if ($urandom_range(0, 7) == 0) send_burst = !send_burst;
    endtask

    task automatic directed(string q, string s);
        push_text(q, 1'b0);
        push_text(s, 1'b1);
        send_request();
    endtask

    // sender goes quiet until every expected result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, bursts without any, one long hold-off
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        int taken;
        bit burst;
        bit held;
        taken = 0;
        burst = 1'b0;
        held  = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken == HOLD_AT && !held) begin
                // long hold-off so the result register fills and input backs up
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = burst ? 0 : $urandom_range(0, 4);
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
            if ($urandom_range(0, 7) == 0) burst = !burst;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int rand_start;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every keyword class, lower case, leading and repeated separators
        directed(" \t\nshow  spaces", "g1");
        directed("use", "");
        directed("EXPLAIN x", "s");
        directed("Profile", "s");
        directed("create space", "s");
        directed("alter edge", "s");
        directed("create INDEX", "s");
        directed("drop label", "s");
        directed("create vertex", "s");
        directed("set x", "s");
        directed("delete", "s");
        directed("merge", "s");
        directed("alter", "");
        directed("match v", "s");
        // over-long first and second words, words beyond the second
        directed("explainx", "s");
        directed("create spacesss", "s");
        directed("go create space", "s");
        directed("create space tag extra", "s");
        // the other separators and the bytes just outside them
        push_text("drop", 1'b0);
        push_byte(8'h0B, 1'b0);
        push_byte(8'h0C, 1'b0);
        push_byte(CH_CR, 1'b0);
        push_text("tag", 1'b0);
        push_byte(8'h0E, 1'b1);
        send_request();
        push_text("s", 1'b0);
        push_byte(8'h08, 1'b0);
        push_text("et", 1'b0);
        push_byte(8'h60, 1'b0);
        push_byte(8'h7B, 1'b1);
        send_request();
        // query text resumes after a space-name beat
        push_text("sho", 1'b0);
        push_byte(8'h80, 1'b1);
        push_text("w index", 1'b0);
        send_request();
        // single-beat requests at the byte extremes
        push_byte(8'hFF, 1'b0);
        send_request();
        push_byte(8'h00, 1'b1);
        send_request();
        drain();

        rand_start = beats_sent;
        while (beats_sent < rand_start + RAND_BEATS) begin
            build_request();
            send_request();
        end
        drain();

        $display("%0d beats sent, %0d results (read %0d, write %0d, ddl %0d, admin %0d)",
                 beats_sent, sb.class_hits.sum(), sb.class_hits[qcph_pkg::QC_READ],
                 sb.class_hits[qcph_pkg::QC_WRITE], sb.class_hits[qcph_pkg::QC_DDL],
                 sb.class_hits[qcph_pkg::QC_ADMIN]);
        $display("input held back for %0d cycles while results were stalled", stall_cycles);
        if (sb.errors == 0) begin
            $display("query_classify_and_partition_hash: match");
        end else begin
            $display("query_classify_and_partition_hash: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/qcph_pkg.sv
rtl/core/qcph_parse.sv
rtl/core/qcph_hash.sv
rtl/core/query_classify_and_partition_hash.sv
test/tb.sv
